>>> rtl/sate_pkg.sv
// Shared codes and types for the shifting array table engine.
// Used by sate_cell, sate_ctrl and the top level; depends on nothing.
package sate_pkg;

	localparam int STEP_W = 4;

	localparam logic [2:0] ACT_APPEND = 3'd0;
	localparam logic [2:0] ACT_UPDATE = 3'd1;
	localparam logic [2:0] ACT_INSERT = 3'd2;
	localparam logic [2:0] ACT_SEARCH = 3'd3;
	localparam logic [2:0] ACT_REMOVE = 3'd4;
	localparam logic [2:0] ACT_READ   = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BADPOS  = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	localparam logic [1:0] OP_HOLD  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_INS   = 2'd2;
	localparam logic [1:0] OP_DEL   = 2'd3;

	typedef struct packed {
		logic              cap;
		logic              scan;
		logic [STEP_W-1:0] step;
		logic [1:0]        op;
	} cell_cmd_t;

endpackage

>>> rtl/sate_cell.sv
// One table cell: holds an entry, its match/prefix flag and a read word.
// Depends on sate_pkg for the command struct and cell operation codes.
module sate_cell #(
	parameter int DW = 32,
	parameter int CW = 5,
	parameter int PW = 5,
	parameter int L  = 4,
	parameter int K  = 0
) (
	input  logic                    clk,
	input  sate_pkg::cell_cmd_t     cmd,
	input  logic [PW-1:0]           idx,
	input  logic [DW-1:0]           val,
	input  logic [CW-1:0]           count,
	input  logic [DW-1:0]           lo_entry,
	input  logic [DW-1:0]           hi_entry,
	input  logic [L-1:0]            nb_p,
	input  logic [L-1:0][DW-1:0]    nb_rd,
	output logic [DW-1:0]           entry,
	output logic                    p,
	output logic [DW-1:0]           rd
);
	import sate_pkg::*;

	logic [DW-1:0] entry_q;
	logic          p_q;
	logic [DW-1:0] rd_q;
	logic          tap_p;
	logic [DW-1:0] tap_rd;

	// pick the neighbor at distance 2^step for this scan step
	always_comb begin
		tap_p  = 1'b0;
		tap_rd = '0;
		for (int j = 0; j < L; j++) begin
			if (cmd.step == STEP_W'(j)) begin
				tap_p  = nb_p[j];
				tap_rd = nb_rd[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			p_q  <= (entry_q == val) && (CW'(K) < count);
			rd_q <= (idx == PW'(K)) ? entry_q : '0;
		end else if (cmd.scan) begin
			p_q  <= p_q | tap_p;
			rd_q <= rd_q | tap_rd;
		end

		unique case (cmd.op)
			OP_HOLD: ;
			OP_WRITE: begin
				if (idx == PW'(K))
					entry_q <= val;
			end
			OP_INS: begin
				if (idx == PW'(K))
					entry_q <= val;
				else if (idx < PW'(K))
					entry_q <= lo_entry;
			end
			OP_DEL: begin
				// every cell at or above the first match pulls from above
				if (p_q)
					entry_q <= hi_entry;
			end
			default: ;
		endcase
	end

	assign entry = entry_q;
	assign p     = p_q;
	assign rd    = rd_q;

endmodule

>>> rtl/sate_ctrl.sv
// Sequencer, count register and result register of the table engine.
// Depends on sate_pkg for action, status and cell operation codes.
module sate_ctrl #(
	parameter int DEPTH = 16,
	parameter int DW    = 32,
	parameter int CW    = 5,
	parameter int PW    = 5,
	parameter int L     = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          action,
	input  logic signed [31:0]  value,
	input  logic [4:0]          position,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic                found,
	output logic signed [31:0]  read_data,
	output logic [4:0]          entry_count,
	output sate_pkg::cell_cmd_t cmd,
	output logic [PW-1:0]       idx,
	output logic [DW-1:0]       val,
	output logic [CW-1:0]       count,
	input  logic                found_top,
	input  logic [DW-1:0]       rd_top
);
	import sate_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic [2:0]        act_q;
	logic [DW-1:0]     val_q;
	logic [PW-1:0]     pos_q;
	logic [PW-1:0]     idx_q;
	logic [CW-1:0]     count_q;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic              found_q;
	logic [31:0]       rdata_q;
	logic [4:0]        ecount_q;

	logic [DW-1:0] val_in;
	logic [31:0]   rd_ext;
	logic [PW-1:0] pos_m1;
	logic          accept;
	logic          fire;
	logic          pos_ok;
	logic          full;
	logic [1:0]    st_d;
	logic          fnd_d;
	logic [31:0]   rd_d;
	logic [CW-1:0] cnt_d;
	logic [1:0]    op_d;

	generate
		if (DW <= 32) begin : g_nar
			assign val_in = value[DW-1:0];
		end else begin : g_wid
			assign val_in = {{(DW-32){value[31]}}, value};
		end
		if (DW >= 32) begin : g_rnar
			assign rd_ext = rd_top[31:0];
		end else begin : g_rwid
			assign rd_ext = {{(32-DW){rd_top[DW-1]}}, rd_top};
		end
	endgenerate

	assign pos_m1   = PW'(position) - PW'(1);
	assign accept   = (state_q == S_IDLE) && in_valid;
	assign in_stall = (state_q != S_IDLE);
	assign fire     = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	assign pos_ok   = (pos_q != '0) && (pos_q <= PW'(count_q));
	assign full     = (count_q == CW'(DEPTH));

	// result and table edit for the item in hand
	always_comb begin
		st_d  = ST_OK;
		fnd_d = 1'b0;
		rd_d  = '0;
		cnt_d = count_q;
		op_d  = OP_HOLD;
		unique case (act_q)
			ACT_APPEND: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					op_d  = OP_WRITE;
					cnt_d = count_q + CW'(1);
				end
			end
			ACT_UPDATE: begin
				if (!pos_ok)
					st_d = ST_BADPOS;
				else
					op_d = OP_WRITE;
			end
			ACT_INSERT: begin
				if (!pos_ok) begin
					st_d = ST_BADPOS;
				end else if (full) begin
					st_d = ST_FULL;
				end else begin
					op_d  = OP_INS;
					cnt_d = count_q + CW'(1);
				end
			end
			ACT_SEARCH: begin
				fnd_d = found_top;
				if (!found_top)
					st_d = ST_MISSING;
			end
			ACT_REMOVE: begin
				fnd_d = found_top;
				if (found_top) begin
					op_d  = OP_DEL;
					cnt_d = count_q - CW'(1);
				end else begin
					st_d = ST_MISSING;
				end
			end
			ACT_READ: begin
				if (!pos_ok)
					st_d = ST_BADPOS;
				else
					rd_d = rd_ext;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q <= '0;
						if (action == ACT_SEARCH || action == ACT_REMOVE ||
						    action == ACT_READ)
							state_q <= S_SCAN;
						else
							state_q <= S_FIN;
					end
				end
				S_SCAN: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(L - 1))
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (fire) begin
						state_q <= S_IDLE;
						count_q <= cnt_d;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (fire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			val_q <= val_in;
			pos_q <= PW'(position);
			idx_q <= (action == ACT_APPEND) ? PW'(count_q) : pos_m1;
		end
		if (fire) begin
			status_q <= st_d;
			found_q  <= fnd_d;
			rdata_q  <= rd_d;
			ecount_q <= 5'(cnt_d);
		end
	end

	always_comb begin
		cmd.cap  = accept;
		cmd.scan = (state_q == S_SCAN);
		cmd.step = step_q;
		cmd.op   = fire ? op_d : OP_HOLD;
	end

	// cells see the incoming beat while idle, the held item afterwards
	assign idx   = (state_q == S_IDLE) ? pos_m1 : idx_q;
	assign val   = (state_q == S_IDLE) ? val_in : val_q;
	assign count = count_q;

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found       = found_q;
	assign read_data   = rdata_q;
	assign entry_count = ecount_q;

endmodule

>>> rtl/shifting_array_table_engine.sv
// Top level of the shifting array table engine: a row of DEPTH cells and
// its sequencer. Depends on sate_pkg, sate_cell and sate_ctrl.
//
// Usage:
//   Input channel in_valid/in_stall carries action, value, position; a
//   beat is taken when in_valid is high and in_stall is low. Output channel
//   out_valid/out_stall carries status, found, read_data, entry_count; one
//   result beat per input beat, in order.
//   One item is in work at a time. Append, update and insert give their
//   result without a scan; search, remove and read first run the prefix
//   scan along the cell row, which doubles its reach at each scan step.
//   in_stall drops in the same cycle that out_valid rises for the result.
//   A result waiting under out_stall does not block the next input beat;
//   the sequencer holds that item's result and table edit until the output
//   register is free.
//   Reset clears the count, the sequencer and the output valid; table
//   contents are not cleared, as only entries below the count are read.
module shifting_array_table_engine #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic signed [31:0] value,
	input  logic [4:0]         position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic               found,
	output logic signed [31:0] read_data,
	output logic [4:0]         entry_count
);
	import sate_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 5) ? CW : 5;
	localparam int L  = $clog2(DEPTH);

	cell_cmd_t     cmd;
	logic [PW-1:0] idx;
	logic [DW-1:0] val;
	logic [CW-1:0] count;

	logic [DW-1:0]         entry_w [DEPTH];
	logic                  p_w     [DEPTH];
	logic [DW-1:0]         rd_w    [DEPTH];
	logic [DW-1:0]         lo_w    [DEPTH];
	logic [DW-1:0]         hi_w    [DEPTH];
	logic [L-1:0]          nb_p    [DEPTH];
	logic [L-1:0][DW-1:0]  nb_rd   [DEPTH];

	sate_ctrl #(
		.DEPTH (DEPTH),
		.DW    (DW),
		.CW    (CW),
		.PW    (PW),
		.L     (L)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.value       (value),
		.position    (position),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.found       (found),
		.read_data   (read_data),
		.entry_count (entry_count),
		.cmd         (cmd),
		.idx         (idx),
		.val         (val),
		.count       (count),
		.found_top   (p_w[DEPTH-1]),
		.rd_top      (rd_w[DEPTH-1])
	);

	genvar k, j;
	generate
		for (k = 0; k < DEPTH; k++) begin : g_cell
			if (k == 0) begin : g_lo0
				assign lo_w[k] = '0;
			end else begin : g_lo
				assign lo_w[k] = entry_w[k-1];
			end
			if (k == DEPTH - 1) begin : g_hit
				assign hi_w[k] = '0;
			end else begin : g_hi
				assign hi_w[k] = entry_w[k+1];
			end
			for (j = 0; j < L; j++) begin : g_tap
				if (k >= (1 << j)) begin : g_on
					assign nb_p[k][j]  = p_w[k - (1 << j)];
					assign nb_rd[k][j] = rd_w[k - (1 << j)];
				end else begin : g_off
					assign nb_p[k][j]  = 1'b0;
					assign nb_rd[k][j] = '0;
				end
			end

			sate_cell #(
				.DW (DW),
				.CW (CW),
				.PW (PW),
				.L  (L),
				.K  (k)
			) u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.idx      (idx),
				.val      (val),
				.count    (count),
				.lo_entry (lo_w[k]),
				.hi_entry (hi_w[k]),
				.nb_p     (nb_p[k]),
				.nb_rd    (nb_rd[k]),
				.entry    (entry_w[k]),
				.p        (p_w[k]),
				.rd       (rd_w[k])
			);
		end
	endgenerate

endmodule
